>>> rtl/tsfp_pkg.sv
// shared types and constants of the target select frame packer
package tsfp_pkg;

  localparam int CLASS_COUNT_DEFAULT = 64;

  localparam int COORD_W  = 16;
  localparam int C2_W     = 18;
  localparam int CENTRE_W = 17;
  localparam int CONF_W   = 10;
  localparam int SQ_W     = 2 * C2_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int CLASS_W  = 6;
  localparam int MASK_W   = 64;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 8;
  localparam int OUT_DATA_W = 8;
  localparam int BYTE_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_MASK = 3'd4;

  localparam logic [CENTRE_W-1:0] CENTRE_X_RESET = 17'd1280;
  localparam logic [CENTRE_W-1:0] CENTRE_Y_RESET = 17'd1024;
  localparam logic [CONF_W-1:0]   MIN_CONF_RESET = 10'd512;

  localparam logic [MODE_W-1:0] MODE_CLOSEST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGH_CONF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LARGEST   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLOSEST_ALT = 2'd3;

  localparam logic [7:0] FRAME_HEAD0 = 8'hFA;
  localparam logic [7:0] FRAME_HEAD1 = 8'hFB;
  localparam logic [7:0] FRAME_TAIL0 = 8'hFC;
  localparam logic [7:0] FRAME_TAIL1 = 8'hFD;

  localparam logic [BYTE_IDX_W-1:0] BYTE_HEAD0 = 3'd0;
  localparam logic [BYTE_IDX_W-1:0] BYTE_HEAD1 = 3'd1;
  localparam logic [BYTE_IDX_W-1:0] BYTE_XLO   = 3'd2;
  localparam logic [BYTE_IDX_W-1:0] BYTE_XHI   = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] BYTE_YLO   = 3'd4;
  localparam logic [BYTE_IDX_W-1:0] BYTE_YHI   = 3'd5;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TAIL0 = 3'd6;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TAIL1 = 3'd7;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              ok;
    logic [C2_W-1:0]   cx2;
    logic [C2_W-1:0]   cy2;
    logic [CONF_W-1:0] conf;
    logic [DIST_W-1:0] dist_sq;
    logic [AREA_W-1:0] area;
  } cand_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } frame_t;

endpackage

>>> rtl/tsfp_front.sv
// input register, qualification, centre, distance and area pipeline
module tsfp_front import tsfp_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [CLASS_W-1:0]    class_id,
  input  logic                  has_box,
  input  logic [COORD_W-1:0]    box_x,
  input  logic [COORD_W-1:0]    box_y,
  input  logic [COORD_W-1:0]    box_width,
  input  logic [COORD_W-1:0]    box_height,
  input  logic [CONF_W-1:0]     confidence,
  input  logic                  last_in_message,
  input  logic [CENTRE_W-1:0]   centre_x,
  input  logic [CENTRE_W-1:0]   centre_y,
  input  logic [CONF_W-1:0]     min_conf,
  input  logic [MASK_W-1:0]     class_mask,
  output cand_t                 cand
);

  localparam logic [CLASS_W:0] CLASS_LIMIT = (CLASS_W + 1)'(CLASS_COUNT);

  // stage 1: input register
  logic               v1, last1, box1;
  logic [CLASS_W-1:0] cls1;
  logic [COORD_W-1:0] bx1, by1, bw1, bh1;
  logic [CONF_W-1:0]  conf1;

  // stage 2: qualified, centres and differences
  logic               v2, last2, ok2;
  logic [C2_W-1:0]    cx2_2, cy2_2, dx2, dy2;
  logic [CONF_W-1:0]  conf2;
  logic [COORD_W-1:0] bw2, bh2;

  // stage 3: products
  logic               v3, last3, ok3;
  logic [C2_W-1:0]    cx2_3, cy2_3;
  logic [CONF_W-1:0]  conf3;
  logic [SQ_W-1:0]    sqx3, sqy3;
  logic [AREA_W-1:0]  area3;

  // stage 4: distance sum
  logic               v4, last4, ok4;
  logic [C2_W-1:0]    cx2_4, cy2_4;
  logic [CONF_W-1:0]  conf4;
  logic [DIST_W-1:0]  dist4;
  logic [AREA_W-1:0]  area4;

  logic            allowed;
  logic [C2_W-1:0] cx2_c, cy2_c, cxc, cyc;

  always_comb begin
    allowed = ({1'b0, cls1} < CLASS_LIMIT) && class_mask[cls1];
    cx2_c = {1'b0, bx1, 1'b0} + {2'b00, bw1};
    cy2_c = {1'b0, by1, 1'b0} + {2'b00, bh1};
    cxc = {1'b0, centre_x};
    cyc = {1'b0, centre_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1 <= last_in_message;
      box1  <= has_box;
      cls1  <= class_id;
      bx1   <= box_x;
      by1   <= box_y;
      bw1   <= box_width;
      bh1   <= box_height;
      conf1 <= confidence;

      last2 <= last1;
      ok2   <= allowed && box1 && (conf1 >= min_conf);
      cx2_2 <= cx2_c;
      cy2_2 <= cy2_c;
      dx2   <= (cx2_c >= cxc) ? cx2_c - cxc : cxc - cx2_c;
      dy2   <= (cy2_c >= cyc) ? cy2_c - cyc : cyc - cy2_c;
      conf2 <= conf1;
      bw2   <= bw1;
      bh2   <= bh1;

      last3 <= last2;
      ok3   <= ok2;
      cx2_3 <= cx2_2;
      cy2_3 <= cy2_2;
      conf3 <= conf2;
      sqx3  <= SQ_W'(dx2) * SQ_W'(dx2);
      sqy3  <= SQ_W'(dy2) * SQ_W'(dy2);
      area3 <= AREA_W'(bw2) * AREA_W'(bh2);

      last4 <= last3;
      ok4   <= ok3;
      cx2_4 <= cx2_3;
      cy2_4 <= cy2_3;
      conf4 <= conf3;
      dist4 <= {1'b0, sqx3} + {1'b0, sqy3};
      area4 <= area3;
    end
  end

  always_comb begin
    cand.valid   = v4;
    cand.last    = last4;
    cand.ok      = ok4;
    cand.cx2     = cx2_4;
    cand.cy2     = cy2_4;
    cand.conf    = conf4;
    cand.dist_sq = dist4;
    cand.area    = area4;
  end

endmodule

>>> rtl/tsfp_select.sv
// best box keeping and frame coordinate rounding
module tsfp_select import tsfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cand_t               cand,
  input  logic [MODE_W-1:0]   mode,
  output frame_t              push
);

  logic               have_best;
  logic [C2_W-1:0]    best_cx2, best_cy2;
  logic [CONF_W-1:0]  best_conf;
  logic [DIST_W-1:0]  best_dist;
  logic [AREA_W-1:0]  best_area;

  logic               better, take, have_next, step;
  logic [C2_W-1:0]    fx2, fy2;
  logic [C2_W:0]      rx, ry;
  logic [C2_W-1:0]    hx, hy;

  always_comb begin
    unique case (mode)
      MODE_HIGH_CONF:   better = cand.conf > best_conf;
      MODE_LARGEST:     better = cand.area > best_area;
      MODE_CLOSEST,
      MODE_CLOSEST_ALT: better = cand.dist_sq < best_dist;
      default:          better = cand.dist_sq < best_dist;
    endcase
    take = cand.ok && (!have_best || better);
    have_next = have_best || cand.ok;
    step = adv && cand.valid;
    fx2 = take ? cand.cx2 : best_cx2;
    fy2 = take ? cand.cy2 : best_cy2;
    // round half up to whole pixels
    rx = {1'b0, fx2} + (C2_W + 1)'(1);
    ry = {1'b0, fy2} + (C2_W + 1)'(1);
    hx = rx[C2_W:1];
    hy = ry[C2_W:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best  <= 1'b0;
      best_cx2   <= '0;
      best_cy2   <= '0;
      best_conf  <= '0;
      best_dist  <= '0;
      best_area  <= '0;
      push.valid <= 1'b0;
      push.x     <= '0;
      push.y     <= '0;
    end else begin
      push.valid <= step && cand.last && have_next;
      if (step) begin
        // saturated coordinates
        push.x <= (hx[C2_W-1:COORD_W] != '0) ? '1 : hx[COORD_W-1:0];
        push.y <= (hy[C2_W-1:COORD_W] != '0) ? '1 : hy[COORD_W-1:0];
        if (cand.last) begin
          have_best <= 1'b0;
          best_cx2  <= '0;
          best_cy2  <= '0;
          best_conf <= '0;
          best_dist <= '0;
          best_area <= '0;
        end else if (take) begin
          have_best <= 1'b1;
          best_cx2  <= cand.cx2;
          best_cy2  <= cand.cy2;
          best_conf <= cand.conf;
          best_dist <= cand.dist_sq;
          best_area <= cand.area;
        end
      end
    end
  end

endmodule

>>> rtl/tsfp_framer.sv
// eight-byte frame serialiser on the output stream
module tsfp_framer import tsfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  frame_t                push,
  output logic                  busy,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [BYTE_IDX_W-1:0] cnt;
  logic [COORD_W-1:0]    fx, fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= BYTE_HEAD0;
    end else if (push.valid) begin
      busy <= 1'b1;
      cnt  <= BYTE_HEAD0;
    end else if (busy && m_tready) begin
      if (cnt == BYTE_TAIL1) begin
        busy <= 1'b0;
      end
      cnt <= cnt + BYTE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      fx <= push.x;
      fy <= push.y;
    end
  end

  always_comb begin
    unique case (cnt)
      BYTE_HEAD0: m_tdata = FRAME_HEAD0;
      BYTE_HEAD1: m_tdata = FRAME_HEAD1;
      BYTE_XLO:   m_tdata = fx[7:0];
      BYTE_XHI:   m_tdata = fx[15:8];
      BYTE_YLO:   m_tdata = fy[7:0];
      BYTE_YHI:   m_tdata = fy[15:8];
      BYTE_TAIL0: m_tdata = FRAME_TAIL0;
      BYTE_TAIL1: m_tdata = FRAME_TAIL1;
      default:    m_tdata = FRAME_TAIL1;
    endcase
    m_tvalid = busy;
    m_tlast  = busy && (cnt == BYTE_TAIL1);
  end

endmodule

>>> rtl/target_select_frame_packer_unit.sv
// top level of the target select frame packer
// a last beat passes the front stages and the select push register before its frame is sent
// throughput: one input beat per cycle; a frame is eight output beats, and a last
// beat waiting on a frame still being sent holds the whole pipeline
// reset: synchronous, clears the registers to their defaults, the kept best
// box and the frame in flight
module target_select_frame_packer_unit import tsfp_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // box_x, box_y, box_width, box_height, confidence, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // class_id, has_box, zero fill
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // frame_byte
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  logic [CENTRE_W-1:0] centre_x, centre_y;
  logic [CONF_W-1:0]   min_conf;
  logic [MODE_W-1:0]   mode;
  logic [MASK_W-1:0]   class_mask;

  cand_t  cand;
  frame_t push;
  logic   frame_busy, adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x   <= CENTRE_X_RESET;
      centre_y   <= CENTRE_Y_RESET;
      min_conf   <= MIN_CONF_RESET;
      mode       <= MODE_CLOSEST;
      class_mask <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTRE_X:   centre_x   <= cfg_wr_data[CENTRE_W-1:0];
        REG_CENTRE_Y:   centre_y   <= cfg_wr_data[CENTRE_W-1:0];
        REG_MIN_CONF:   min_conf   <= cfg_wr_data[CONF_W-1:0];
        REG_MODE:       mode       <= cfg_wr_data[MODE_W-1:0];
        REG_CLASS_MASK: class_mask <= cfg_wr_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // a frame needs the serialiser free before the last beat may pass
  assign adv = !(cand.valid && cand.last && (frame_busy || push.valid));
  assign s_tready = adv;

  tsfp_front #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (s_tvalid),
    .class_id       (s_tuser[5:0]),
    .has_box        (s_tuser[6]),
    .box_x          (s_tdata[15:0]),
    .box_y          (s_tdata[31:16]),
    .box_width      (s_tdata[47:32]),
    .box_height     (s_tdata[63:48]),
    .confidence     (s_tdata[73:64]),
    .last_in_message(s_tlast),
    .centre_x       (centre_x),
    .centre_y       (centre_y),
    .min_conf       (min_conf),
    .class_mask     (class_mask),
    .cand           (cand)
  );

  tsfp_select u_select (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cand(cand),
    .mode(mode),
    .push(push)
  );

  tsfp_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .busy    (frame_busy),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !frame_busy)
    else $error("frame pushed while serialiser busy");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (frame_busy || push.valid))
    else $error("input stalled with serialiser free");

  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output beat after end of frame");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    push.valid |=> (m_tvalid && (m_tdata == FRAME_HEAD0)))
    else $error("frame did not start with header");

endmodule

>>> tb/sv/target_select_frame_packer_checker.sv
// frame checker: predicts the frame beats from accepted boxes and compares them with the output
module target_select_frame_packer_checker import tsfp_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // box_x, box_y, box_width, box_height, confidence, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // class_id, has_box, zero fill
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // frame_byte
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output int                    errors,
  output int                    pending_beats,
  output int                    beats_checked,
  output int                    boxes_seen,
  output int                    messages_seen
);

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] octet;
    logic                  tail;
  } frame_beat_t;

  frame_beat_t frame_beats_due[$];

  logic [CENTRE_W-1:0] centre_x;
  logic [CENTRE_W-1:0] centre_y;
  logic [CONF_W-1:0]   conf_floor;
  logic [MODE_W-1:0]   pick_mode;
  logic [MASK_W-1:0]   class_allow;

  logic                kept;
  logic [C2_W-1:0]     kept_cx2;
  logic [C2_W-1:0]     kept_cy2;
  logic [CONF_W-1:0]   kept_conf;
  logic [DIST_W-1:0]   kept_dist;
  logic [AREA_W-1:0]   kept_area;

  // doubled centre to whole pixels, half-up, saturated
  function automatic logic [COORD_W-1:0] round_to_pixel(input logic [C2_W-1:0] c2);
    logic [C2_W:0] v;
    v = ({1'b0, c2} + (C2_W + 1)'(1)) >> 1;
    return (v[C2_W:COORD_W] != '0) ? {COORD_W{1'b1}} : v[COORD_W-1:0];
  endfunction

  task automatic forget_best();
    kept      = 1'b0;
    kept_cx2  = '0;
    kept_cy2  = '0;
    kept_conf = '0;
    kept_dist = '0;
    kept_area = '0;
  endtask

  task automatic queue_frame();
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [OUT_DATA_W-1:0] octets [8];
    x = round_to_pixel(kept_cx2);
    y = round_to_pixel(kept_cy2);
    octets = '{FRAME_HEAD0, FRAME_HEAD1, x[7:0], x[15:8], y[7:0], y[15:8],
               FRAME_TAIL0, FRAME_TAIL1};
    for (int k = 0; k < 8; k++) frame_beats_due.push_back({octets[k], k == 7});
  endtask

  task automatic absorb_box(input logic [IN_DATA_W-1:0] d, input logic [IN_USER_W-1:0] u,
                            input logic ends_msg);
    logic [CLASS_W-1:0] cls;
    logic               has;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bw;
    logic [COORD_W-1:0] bh;
    logic [CONF_W-1:0]  conf;
    logic [C2_W-1:0]    cx2;
    logic [C2_W-1:0]    cy2;
    logic [C2_W-1:0]    cxc;
    logic [C2_W-1:0]    cyc;
    logic [C2_W-1:0]    dx;
    logic [C2_W-1:0]    dy;
    logic [DIST_W-1:0]  dist_sq;
    logic [AREA_W-1:0]  area;
    logic               take;
    bx   = d[15:0];
    by   = d[31:16];
    bw   = d[47:32];
    bh   = d[63:48];
    conf = d[73:64];
    cls  = u[5:0];
    has  = u[6];
    cxc  = {1'b0, centre_x};
    cyc  = {1'b0, centre_y};
    if ((int'(cls) < CLASS_COUNT) && class_allow[cls] && has && conf >= conf_floor) begin
      cx2  = {1'b0, bx, 1'b0} + {2'b00, bw};
      cy2  = {1'b0, by, 1'b0} + {2'b00, bh};
      dx   = (cx2 >= cxc) ? cx2 - cxc : cxc - cx2;
      dy   = (cy2 >= cyc) ? cy2 - cyc : cyc - cy2;
      dist_sq = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
      area = AREA_W'(bw) * AREA_W'(bh);
      if (!kept) begin
        take = 1'b1;
      end else begin
        case (pick_mode)
          MODE_HIGH_CONF: take = conf > kept_conf;
          MODE_LARGEST:   take = area > kept_area;
          default:        take = dist_sq < kept_dist;
        endcase
      end
      if (take) begin
        kept      = 1'b1;
        kept_cx2  = cx2;
        kept_cy2  = cy2;
        kept_conf = conf;
        kept_dist = dist_sq;
        kept_area = area;
      end
    end
    if (ends_msg) begin
      messages_seen++;
      if (kept) queue_frame();
      forget_best();
    end
  endtask

  always @(posedge clk) begin : watch
    frame_beat_t due;
    if (rst) begin
      centre_x    = CENTRE_X_RESET;
      centre_y    = CENTRE_Y_RESET;
      conf_floor  = MIN_CONF_RESET;
      pick_mode   = MODE_CLOSEST;
      class_allow = '1;
      forget_best();
      frame_beats_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CENTRE_X:   centre_x    = cfg_wr_data[CENTRE_W-1:0];
          REG_CENTRE_Y:   centre_y    = cfg_wr_data[CENTRE_W-1:0];
          REG_MIN_CONF:   conf_floor  = cfg_wr_data[CONF_W-1:0];
          REG_MODE:       pick_mode   = cfg_wr_data[MODE_W-1:0];
          REG_CLASS_MASK: class_allow = cfg_wr_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (frame_beats_due.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("frame beat %02h (end %b) arrived with none due", m_tdata, m_tlast);
        end else begin
          due = frame_beats_due.pop_front();
          beats_checked++;
          if (m_tdata !== due.octet || m_tlast !== due.tail) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("frame beat %0d: expected %02h end %b, got %02h end %b",
                       beats_checked, due.octet, due.tail, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        boxes_seen++;
        absorb_box(s_tdata, s_tuser, s_tlast);
      end
    end
    pending_beats = frame_beats_due.size();
  end

endmodule

>>> tb/sv/target_select_frame_packer_unit_test.sv
// testbench top: drives boxes and register writes into the frame packer and gives the verdict
module target_select_frame_packer_unit_test;
  import tsfp_pkg::*;

  localparam int CLASS_COUNT    = CLASS_COUNT_DEFAULT;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BOXES    = 85;
  localparam int PRESSURE_BOXES = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  int errors;
  int pending_beats;
  int beats_checked;
  int boxes_seen;
  int messages_seen;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count   = 0;
  logic pressure_go   = 1'b0;
  logic hold_off      = 1'b0;

  logic [CONF_W-1:0]  floor_now = MIN_CONF_RESET;
  logic [COORD_W-1:0] prev_x = '0;
  logic [COORD_W-1:0] prev_y = '0;
  logic [COORD_W-1:0] prev_w = '0;
  logic [COORD_W-1:0] prev_h = '0;

  always #1 clk = ~clk;

  target_select_frame_packer_unit #(.CLASS_COUNT(CLASS_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  target_select_frame_packer_checker #(.CLASS_COUNT(CLASS_COUNT)) frame_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .pending_beats(pending_beats), .beats_checked(beats_checked),
    .boxes_seen(boxes_seen), .messages_seen(messages_seen)
  );

  always @(posedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // long output hold so the block fills and back-pressures its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("target_select_frame_packer_unit_test: errors");
      $finish;
    end
  end

  task automatic send_box(input logic [CLASS_W-1:0] cls, input logic has,
                          input logic [COORD_W-1:0] x, y, w, h,
                          input logic [CONF_W-1:0] conf, input logic ends_msg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 74){1'b0}}, conf, h, w, y, x};
    s_tuser  <= {{(IN_USER_W - 7){1'b0}}, has, cls};
    s_tlast  <= ends_msg;
    @(negedge clk);
    while (!s_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    if (idx == REG_MIN_CONF) floor_now = value[CONF_W-1:0];
    @(posedge clk);
  endtask

  // wait for every frame beat due, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_beats != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(input logic [CENTRE_W-1:0] cx, cy, input logic [CONF_W-1:0] fl,
                           input logic [MODE_W-1:0] md, input logic [MASK_W-1:0] msk);
    settle();
    write_reg(REG_CENTRE_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTRE_Y, CFG_DATA_W'(cy));
    write_reg(REG_MIN_CONF, CFG_DATA_W'(fl));
    write_reg(REG_MODE, CFG_DATA_W'(md));
    write_reg(REG_CLASS_MASK, msk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_box(input logic ends_msg);
    logic [CLASS_W-1:0] cls;
    logic               has;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [CONF_W-1:0]  conf;
    cls = CLASS_W'($urandom);
    has = $urandom_range(99) < 88;
    if ($urandom_range(99) < 80) conf = CONF_W'($urandom_range(1023, floor_now));
    else conf = CONF_W'($urandom);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    w = COORD_W'($urandom);
    h = COORD_W'($urandom);
    case ($urandom_range(9))
      0: begin
        x = '0;
        y = '0;
      end
      1: begin
        x = '1;
        y = '1;
        w = '1;
        h = '1;
      end
      // repeat the last box's position and size so distance and area ties come up
      2: begin
        x = prev_x;
        y = prev_y;
        w = prev_w;
        h = prev_h;
      end
      3: begin
        w = COORD_W'($urandom_range(15));
        h = COORD_W'($urandom_range(15));
      end
      default: ;
    endcase
    prev_x = x;
    prev_y = y;
    prev_w = w;
    prev_h = h;
    send_box(cls, has, x, y, w, h, conf, ends_msg);
  endtask

  task automatic random_run(input int count, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(max_len, 1);
      for (int k = 0; k < len; k++) random_box(k == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of position and size, at full confidence
    send_box(6'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 10'd1023, 1'b1);
    send_box(6'd63, 1'b1, '1, '1, '1, '1, 10'd1023, 1'b1);
    // confidence on the floor, half-up rounding, then a skipped last box
    send_box(6'd17, 1'b1, 16'd10, 16'd20, 16'd1, 16'd3, MIN_CONF_RESET, 1'b0);
    send_box(6'd17, 1'b1, 16'd640, 16'd512, 16'd0, 16'd0, MIN_CONF_RESET - 10'd1, 1'b1);
    // equal distance either side of centre, first box stays
    send_box(6'd3, 1'b1, 16'd630, 16'd512, 16'd0, 16'd0, 10'd600, 1'b0);
    send_box(6'd4, 1'b1, 16'd650, 16'd512, 16'd0, 16'd0, 10'd600, 1'b1);
    // messages that end with nothing kept
    send_box(6'd9, 1'b0, 16'd640, 16'd512, 16'd4, 16'd4, 10'd1023, 1'b1);
    send_box(6'd9, 1'b1, 16'd640, 16'd512, 16'd4, 16'd4, 10'd0, 1'b1);
    // nearer box replaces a farther one
    send_box(6'd1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 10'd900, 1'b0);
    send_box(6'd2, 1'b1, 16'd639, 16'd511, 16'd2, 16'd2, 10'd700, 1'b0);
    send_box(6'd1, 1'b1, 16'd100, 16'd900, 16'd6, 16'd6, 10'd1000, 1'b1);

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_HIGH_CONF));
    cfg_wr_en <= 1'b0;
    send_box(6'd5, 1'b1, 16'd10, 16'd10, 16'd5, 16'd5, 10'd700, 1'b0);
    send_box(6'd6, 1'b1, 16'd20, 16'd30, 16'd5, 16'd5, 10'd800, 1'b0);
    send_box(6'd7, 1'b1, 16'd40, 16'd50, 16'd5, 16'd5, 10'd800, 1'b1);

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LARGEST));
    cfg_wr_en <= 1'b0;
    send_box(6'd8, 1'b1, 16'd300, 16'd200, 16'd100, 16'd100, 10'd600, 1'b0);
    send_box(6'd8, 1'b1, 16'd310, 16'd210, 16'd200, 16'd1, 10'd600, 1'b0);
    send_box(6'd8, 1'b1, 16'd320, 16'd220, 16'd100, 16'd100, 10'd600, 1'b1);

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CLOSEST_ALT));
    cfg_wr_en <= 1'b0;
    send_box(6'd11, 1'b1, 16'd638, 16'd510, 16'd3, 16'd5, 10'd513, 1'b0);
    send_box(6'd12, 1'b1, 16'd2000, 16'd40, 16'd9, 16'd9, 10'd1023, 1'b1);

    // no class allowed, then only the top class; stray indexes must change nothing
    settle();
    write_reg(REG_CLASS_MASK, '0);
    write_reg(REG_MIN_CONF, '0);
    cfg_wr_en <= 1'b0;
    send_box(6'd5, 1'b1, 16'd50, 16'd60, 16'd7, 16'd7, 10'd1023, 1'b1);
    settle();
    write_reg(REG_CLASS_MASK, 64'h8000_0000_0000_0000);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, '1);
    cfg_wr_en <= 1'b0;
    send_box(6'd63, 1'b1, 16'd70, 16'd80, 16'd3, 16'd4, 10'd0, 1'b1);
    send_box(6'd62, 1'b1, 16'd70, 16'd80, 16'd3, 16'd4, 10'd1023, 1'b1);

    set_phase('0, '1, '0, MODE_HIGH_CONF, {$urandom, $urandom});
    send_idle_pct = 14;
    recv_idle_pct = 72;
    random_run(PHASE_BOXES, 5);

    set_phase(CENTRE_W'($urandom), CENTRE_W'($urandom), '1, MODE_LARGEST,
              {$urandom, $urandom} | {$urandom, $urandom});
    send_idle_pct = 72;
    recv_idle_pct = 14;
    random_run(PHASE_BOXES, 5);

    set_phase(CENTRE_W'($urandom), CENTRE_W'($urandom), CONF_W'($urandom_range(600)),
              MODE_CLOSEST, '1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go   = 1'b1;
    random_run(PRESSURE_BOXES, 1);

    set_phase('1, '0, CONF_W'($urandom_range(700)), MODE_CLOSEST_ALT,
              {$urandom, $urandom} | {$urandom, $urandom});
    random_run(PHASE_BOXES, 5);
    settle();

    $display("run: %0d boxes in %0d messages, %0d frame beats checked",
             boxes_seen, messages_seen, beats_checked);
    $display("run: all four modes, floor and class mask extremes, stray indexes, %0d-cycle hold",
             HOLD_CYCLES);
    if (errors == 0 && pending_beats == 0) begin
      $display("target_select_frame_packer_unit_test: clean");
    end else begin
      $display("target_select_frame_packer_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tsfp_pkg.sv
rtl/tsfp_front.sv
rtl/tsfp_select.sv
rtl/tsfp_framer.sv
rtl/target_select_frame_packer_unit.sv
tb/sv/target_select_frame_packer_checker.sv
tb/sv/target_select_frame_packer_unit_test.sv
